>>> hw/rtl/mer_pkg.sv
package mer_pkg;

  // Semi-axis width; every other width follows from it.
  localparam int RadiusBits = 5;
  localparam int CenterW    = RadiusBits + 1;
  localparam int CoordW     = RadiusBits + 2;
  localparam int SqW        = 2 * RadiusBits;
  localparam int CntW       = RadiusBits + 1;
  localparam int MulW       = 2 * RadiusBits + 5;
  localparam int DecW       = 4 * RadiusBits + 6;

  // Result cap: all ones in the counter.
  localparam logic [CntW-1:0] NMax = {CntW{1'b1}};

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQX,
    OP_SQY,
    OP_RXY,
    OP_D1,
    OP_D2A,
    OP_D2B,
    OP_D2C,
    OP_D2D,
    OP_D2E,
    OP_D2F,
    OP_STEP1,
    OP_STEP2
  } dp_op_e;

  typedef struct packed {
    logic   load;
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic r1_go;
    logic r2_go;
    logic out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/mer_ctrl.sv
module mer_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mer_pkg::dp_sts_t  sts_i,
  output mer_pkg::dp_cmd_t  cmd_o
);
  import mer_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_RXY,
    ST_D1,
    ST_R1,
    ST_D2A,
    ST_D2B,
    ST_D2C,
    ST_D2D,
    ST_D2E,
    ST_D2F,
    ST_R2
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = ST_RXY;
      end
      ST_RXY: begin
        cmd_o.op = OP_RXY;
        state_d  = ST_D1;
      end
      ST_D1: begin
        cmd_o.op = OP_D1;
        state_d  = ST_R1;
      end
      ST_R1: begin
        if (!sts_i.r1_go) begin
          state_d = ST_D2A;
        end else if (sts_i.out_free) begin
          cmd_o.op = OP_STEP1;
        end
      end
      ST_D2A: begin
        cmd_o.op = OP_D2A;
        state_d  = ST_D2B;
      end
      ST_D2B: begin
        cmd_o.op = OP_D2B;
        state_d  = ST_D2C;
      end
      ST_D2C: begin
        cmd_o.op = OP_D2C;
        state_d  = ST_D2D;
      end
      ST_D2D: begin
        cmd_o.op = OP_D2D;
        state_d  = ST_D2E;
      end
      ST_D2E: begin
        cmd_o.op = OP_D2E;
        state_d  = ST_D2F;
      end
      ST_D2F: begin
        cmd_o.op = OP_D2F;
        state_d  = ST_R2;
      end
      ST_R2: begin
        if (!sts_i.r2_go) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.op = OP_STEP2;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/mer_dp.sv
module mer_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  mer_pkg::dp_cmd_t                        cmd_i,
  output mer_pkg::dp_sts_t                        sts_o,
  input  logic signed [mer_pkg::CenterW-1:0]      center_x_i,
  input  logic signed [mer_pkg::CenterW-1:0]      center_y_i,
  input  logic        [mer_pkg::RadiusBits-1:0]   radius_x_i,
  input  logic        [mer_pkg::RadiusBits-1:0]   radius_y_i,
  input  logic        [7:0]                       symbol_i,
  input  logic                                    out_stall_i,
  output logic                                    out_valid_o,
  output logic signed [mer_pkg::CoordW-1:0]       right_x_o,
  output logic signed [mer_pkg::CoordW-1:0]       left_x_o,
  output logic signed [mer_pkg::CoordW-1:0]       upper_y_o,
  output logic signed [mer_pkg::CoordW-1:0]       lower_y_o,
  output logic        [7:0]                       plot_symbol_o,
  output logic                                    last_o
);
  import mer_pkg::*;

  // request
  logic        [CoordW-1:0]     cx_q, cy_q;
  logic        [RadiusBits-1:0] rx_q, ry_q;
  logic        [7:0]            sym_q;
  // walk
  logic        [CoordW-1:0]     x_q;
  logic signed [CoordW-1:0]     y_q;
  logic        [CntW-1:0]       n_q;
  logic        [SqW-1:0]        rx2_q, ry2_q;
  logic signed [DecW-1:0]       dx_q, dy_q, d_q, acc_q, prod_q;
  // result register
  logic                         out_valid_q;
  logic        [CoordW-1:0]     rx_out_q, lx_out_q, uy_out_q, ly_out_q;
  logic        [7:0]            sym_out_q;
  logic                         last_q;

  logic signed [DecW-1:0]       rx2_s, ry2_s;
  logic signed [CoordW-1:0]     ym1;
  logic signed [MulW-1:0]       mul_a, mul_b;
  logic signed [2*MulW-1:0]     mul_p;
  logic signed [DecW-1:0]       dx_n, dy_n, d1_n, d2_n;
  logic                         emit, last_n;

  assign rx2_s = $signed({{(DecW-SqW){1'b0}}, rx2_q});
  assign ry2_s = $signed({{(DecW-SqW){1'b0}}, ry2_q});
  assign ym1   = y_q - $signed({{(CoordW-1){1'b0}}, 1'b1});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_SQX: begin
        mul_a = $signed({{(MulW-RadiusBits){1'b0}}, rx_q});
        mul_b = mul_a;
      end
      OP_SQY: begin
        mul_a = $signed({{(MulW-RadiusBits){1'b0}}, ry_q});
        mul_b = mul_a;
      end
      OP_RXY: begin
        mul_a = $signed({{(MulW-SqW){1'b0}}, rx2_q});
        mul_b = $signed({{(MulW-RadiusBits){1'b0}}, ry_q});
      end
      OP_D2A: begin
        // 2x+1
        mul_a = $signed({{(MulW-CoordW-1){1'b0}}, x_q, 1'b1});
        mul_b = mul_a;
      end
      OP_D2B: begin
        mul_a = $signed({{(MulW-SqW){1'b0}}, ry2_q});
        mul_b = prod_q[MulW-1:0];
      end
      OP_D2C: begin
        mul_a = $signed({{(MulW-CoordW){ym1[CoordW-1]}}, ym1});
        mul_b = mul_a;
      end
      OP_D2D: begin
        mul_a = $signed({{(MulW-SqW){1'b0}}, rx2_q});
        mul_b = prod_q[MulW-1:0];
      end
      OP_D2E: begin
        mul_a = $signed({{(MulW-SqW){1'b0}}, rx2_q});
        mul_b = $signed({{(MulW-SqW){1'b0}}, ry2_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // one midpoint step for each region
  always_comb begin
    dx_n = dx_q + (ry2_s <<< 1);
    dy_n = dy_q - (rx2_s <<< 1);
    if (d_q < 0) begin
      d1_n = d_q + ((dx_n + ry2_s) <<< 2);
    end else begin
      d1_n = d_q + ((dx_n - dy_n + ry2_s) <<< 2);
    end
    if (d_q > 0) begin
      d2_n = d_q + ((rx2_s - dy_n) <<< 2);
    end else begin
      d2_n = d_q + ((dx_n - dy_n + rx2_s) <<< 2);
    end
  end

  assign emit = (cmd_i.op == OP_STEP1) || (cmd_i.op == OP_STEP2);
  assign last_n = (n_q == NMax - 1'b1) ||
                  ((cmd_i.op == OP_STEP2) && (y_q == '0));

  assign sts_o.r1_go    = (dx_q < dy_q) && (n_q != NMax);
  assign sts_o.r2_go    = !y_q[CoordW-1] && (n_q != NMax);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      if (cmd_i.load) begin
        n_q <= '0;
      end else if (emit) begin
        n_q <= n_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q  <= {center_x_i[CenterW-1], center_x_i};
      cy_q  <= {center_y_i[CenterW-1], center_y_i};
      rx_q  <= radius_x_i;
      ry_q  <= radius_y_i;
      sym_q <= symbol_i;
      x_q   <= '0;
      y_q   <= $signed({2'b00, radius_y_i});
    end
    case (cmd_i.op)
      OP_SQX: begin
        prod_q <= mul_p[DecW-1:0];
      end
      OP_SQY: begin
        rx2_q  <= prod_q[SqW-1:0];
        prod_q <= mul_p[DecW-1:0];
      end
      OP_RXY: begin
        ry2_q  <= prod_q[SqW-1:0];
        prod_q <= mul_p[DecW-1:0];
      end
      OP_D1: begin
        dx_q <= '0;
        dy_q <= prod_q <<< 1;
        d_q  <= (ry2_s <<< 2) - (prod_q <<< 2) + rx2_s;
      end
      OP_D2A, OP_D2B, OP_D2D: begin
        prod_q <= mul_p[DecW-1:0];
      end
      OP_D2C: begin
        acc_q  <= prod_q;
        prod_q <= mul_p[DecW-1:0];
      end
      OP_D2E: begin
        acc_q  <= acc_q + (prod_q <<< 2);
        prod_q <= mul_p[DecW-1:0];
      end
      OP_D2F: begin
        d_q <= acc_q - (prod_q <<< 2);
      end
      OP_STEP1: begin
        x_q  <= x_q + 1'b1;
        dx_q <= dx_n;
        d_q  <= d1_n;
        if (d_q >= 0) begin
          y_q  <= ym1;
          dy_q <= dy_n;
        end
      end
      OP_STEP2: begin
        y_q  <= ym1;
        dy_q <= dy_n;
        d_q  <= d2_n;
        if (d_q <= 0) begin
          x_q  <= x_q + 1'b1;
          dx_q <= dx_n;
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      rx_out_q  <= cx_q + x_q;
      lx_out_q  <= cx_q - x_q;
      uy_out_q  <= cy_q + y_q;
      ly_out_q  <= cy_q - y_q;
      sym_out_q <= sym_q;
      last_q    <= last_n;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign right_x_o     = $signed(rx_out_q);
  assign left_x_o      = $signed(lx_out_q);
  assign upper_y_o     = $signed(uy_out_q);
  assign lower_y_o     = $signed(ly_out_q);
  assign plot_symbol_o = sym_out_q;
  assign last_o        = last_q;

endmodule

>>> hw/rtl/midpoint_ellipse_raster_top.sv
// Channel  Dir  Handshake               Fields
// in       in   in_valid_i/in_stall_o   center_x, center_y, radius_x, radius_y, symbol
// out      out  out_valid_o/out_stall_i right_x, left_x, upper_y, lower_y, plot_symbol, last
//
// From one accept to the next, an ellipse passes through the accept state, the
// setup states (squares and region one decision), the region two setup states,
// most of them on the shared multiplier, an exit state per region, and P point
// groups at one per cycle while out is not stalled (P <= 63).
// The request is taken only when the controller is idle; reset clears the
// controller state and the result valid flag. A stalled result holds in the
// output register; the walk waits on it.
module midpoint_ellipse_raster_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [mer_pkg::CenterW-1:0]      center_x_i,
  input  logic signed [mer_pkg::CenterW-1:0]      center_y_i,
  input  logic        [mer_pkg::RadiusBits-1:0]   radius_x_i,
  input  logic        [mer_pkg::RadiusBits-1:0]   radius_y_i,
  input  logic        [7:0]                       symbol_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [mer_pkg::CoordW-1:0]       right_x_o,
  output logic signed [mer_pkg::CoordW-1:0]       left_x_o,
  output logic signed [mer_pkg::CoordW-1:0]       upper_y_o,
  output logic signed [mer_pkg::CoordW-1:0]       lower_y_o,
  output logic        [7:0]                       plot_symbol_o,
  output logic                                    last_o
);
  import mer_pkg::*;

  // Commands go down to the datapath, loop and output status come back.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: setup steps, region one walk, region two setup, region two walk.
  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Decision registers, shared multiplier and the result register.
  mer_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_x_i    (radius_x_i),
    .radius_y_i    (radius_y_i),
    .symbol_i      (symbol_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .right_x_o     (right_x_o),
    .left_x_o      (left_x_o),
    .upper_y_o     (upper_y_o),
    .lower_y_o     (lower_y_o),
    .plot_symbol_o (plot_symbol_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // A taken request keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after a request was taken");

  // A point group is only written into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd.op == OP_STEP1) || (cmd.op == OP_STEP2)) |-> sts.out_free)
    else $error("point group written over a pending result");

  // The request registers are loaded only while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!in_stall_o && (cmd.op == OP_NONE)))
    else $error("request loaded while busy");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  import mer_pkg::*;

  localparam int CW = mer_pkg::CenterW;
  localparam int PW = mer_pkg::CoordW;
  localparam int RW = mer_pkg::RadiusBits;

  // Point groups per ellipse never exceed this (walk counter all ones).
  localparam int MaxGroups = (1 << (RW + 1)) - 1;

  localparam int ResetCycles = 6;
  localparam int HoldOffCycles = 400;
  localparam int DrainCycles = 100;
  localparam int CycleLimit = 1000000;
  localparam int ItemsPerPhase = 110;

  typedef struct {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic [RW-1:0] radius_x;
    logic [RW-1:0] radius_y;
    logic [7:0] symbol;
  } ellipse_req_t;

  typedef struct {
    logic signed [PW-1:0] right_x;
    logic signed [PW-1:0] left_x;
    logic signed [PW-1:0] upper_y;
    logic signed [PW-1:0] lower_y;
    logic [7:0] plot_symbol;
    logic last;
  } point_group_t;

  // Expected point groups in emission order, one entry per output item.
  class ellipse_scoreboard;
    point_group_t plot_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return plot_q.size();
    endfunction

    function void push_group(longint cx, longint cy, longint x, longint y,
                             logic [7:0] sym);
      point_group_t g;
      longint t;
      t = cx + x; g.right_x = t[PW-1:0];
      t = cx - x; g.left_x = t[PW-1:0];
      t = cy + y; g.upper_y = t[PW-1:0];
      t = cy - y; g.lower_y = t[PW-1:0];
      g.plot_symbol = sym;
      g.last = 1'b0;
      plot_q.insert(plot_q.size(), g);
    endfunction

    // Two-region midpoint walk, decision terms scaled by four.
    function void add_ellipse(ellipse_req_t req);
      longint cx, cy, rx, ry, rx2, ry2, x, y, dx, dy, d;
      int n;
      cx = req.center_x;
      cy = req.center_y;
      rx = req.radius_x;
      ry = req.radius_y;
      rx2 = rx * rx;
      ry2 = ry * ry;
      x = 0;
      y = ry;
      dx = 0;
      dy = 2 * rx2 * y;
      n = 0;

      d = 4 * ry2 - 4 * rx2 * ry + rx2;
      while (dx < dy && n < MaxGroups) begin
        push_group(cx, cy, x, y, req.symbol);
        n++;
        x++;
        dx += 2 * ry2;
        if (d < 0) begin
          d += 4 * (dx + ry2);
        end else begin
          y--;
          dy -= 2 * rx2;
          d += 4 * (dx - dy + ry2);
        end
      end

      d = ry2 * (2 * x + 1) * (2 * x + 1) + 4 * rx2 * (y - 1) * (y - 1)
          - 4 * rx2 * ry2;
      while (y >= 0 && n < MaxGroups) begin
        push_group(cx, cy, x, y, req.symbol);
        n++;
        y--;
        dy -= 2 * rx2;
        if (d > 0) begin
          d += 4 * (rx2 - dy);
        end else begin
          x++;
          dx += 2 * ry2;
          d += 4 * (dx - dy + rx2);
        end
      end

      if (n > 0) plot_q[plot_q.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_group(point_group_t got);
      point_group_t want;
      if (plot_q.size() == 0) begin
        report($sformatf("unexpected point group x=%0d/%0d y=%0d/%0d sym=%0h last=%0b",
                         got.right_x, got.left_x, got.upper_y, got.lower_y,
                         got.plot_symbol, got.last));
      end else begin
        want = plot_q.pop_front();
        if (got.right_x !== want.right_x || got.left_x !== want.left_x ||
            got.upper_y !== want.upper_y || got.lower_y !== want.lower_y ||
            got.plot_symbol !== want.plot_symbol || got.last !== want.last) begin
          report({$sformatf("got x=%0d/%0d y=%0d/%0d sym=%0h last=%0b",
                            got.right_x, got.left_x, got.upper_y, got.lower_y,
                            got.plot_symbol, got.last),
                  $sformatf(", want x=%0d/%0d y=%0d/%0d sym=%0h last=%0b",
                            want.right_x, want.left_x, want.upper_y,
                            want.lower_y, want.plot_symbol, want.last)});
        end
      end
    endtask
  endclass

  // DUT signals, all inputs known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] center_x_i = '0;
  logic signed [CW-1:0] center_y_i = '0;
  logic [RW-1:0] radius_x_i = '0;
  logic [RW-1:0] radius_y_i = '0;
  logic [7:0] symbol_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [PW-1:0] right_x_o;
  logic signed [PW-1:0] left_x_o;
  logic signed [PW-1:0] upper_y_o;
  logic signed [PW-1:0] lower_y_o;
  logic [7:0] plot_symbol_o;
  logic last_o;

  // Idle rates in percent; phase 2 turns on the long receiver hold-off
  int unsigned sender_idle_pct = 13;
  int unsigned receiver_idle_pct = 84;
  int unsigned stim_phase = 0;
  logic hold_off = 1'b0;
  int unsigned cycle_count = 0;

  ellipse_scoreboard scoreboard = new();

  midpoint_ellipse_raster_top u_dut (.*);

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Global watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: values read here are the ones present at the edge, since
  // every tb drive is nonblocking. Stall for the next cycle is picked after
  // the check so the read and the update never race.
  always @(posedge clk_i) begin
    point_group_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.right_x = right_x_o;
      got.left_x = left_x_o;
      got.upper_y = upper_y_o;
      got.lower_y = lower_y_o;
      got.plot_symbol = plot_symbol_o;
      got.last = last_o;
      scoreboard.check_group(got);
    end
    out_stall_i <= hold_off || ($urandom_range(99) < receiver_idle_pct);
  end

  // Long back-pressure once the sender stops idling: the output register
  // and walker fill up and the block has to stall new ellipses.
  initial begin
    wait (stim_phase == 2);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic ellipse_req_t make_req(int cx, int cy, int rx, int ry, int sym);
    ellipse_req_t r;
    r.center_x = CW'(cx);
    r.center_y = CW'(cy);
    r.radius_x = RW'(rx);
    r.radius_y = RW'(ry);
    r.symbol = 8'(sym);
    return r;
  endfunction

  // Mostly small ellipses for throughput, some up to the full radius range.
  function automatic ellipse_req_t random_req();
    int rmax;
    rmax = ($urandom_range(99) < 60) ? 12 : (1 << RW) - 1;
    return make_req($urandom_range((1 << CW) - 1), $urandom_range((1 << CW) - 1),
                    $urandom_range(rmax), $urandom_range(rmax),
                    $urandom_range(255));
  endfunction

  // Offer one ellipse, with random idle cycles ahead of it. Valid stays high
  // across back-to-back items and the payload holds while stalled.
  task automatic send_ellipse(ellipse_req_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    center_x_i <= req.center_x;
    center_y_i <= req.center_y;
    radius_x_i <= req.radius_x;
    radius_y_i <= req.radius_y;
    symbol_i <= req.symbol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scoreboard.add_ellipse(req);
  endtask

  initial begin
    ellipse_req_t directed_q[$];
    int sent;

    // Corner cases: zero radii (single group, or a vertical walk on x = 0),
    // full radii at both center extremes, thin ellipses, symbol extremes.
    directed_q.insert(directed_q.size(), make_req(0, 0, 0, 0, 8'h00));
    directed_q.insert(directed_q.size(), make_req(5, -3, 0, 31, 8'hFF));
    directed_q.insert(directed_q.size(), make_req(-7, 9, 31, 0, 8'h41));
    directed_q.insert(directed_q.size(), make_req(31, 31, 31, 31, 8'h2A));
    directed_q.insert(directed_q.size(), make_req(-32, -32, 31, 31, 8'hFF));
    directed_q.insert(directed_q.size(), make_req(1, 1, 1, 1, 8'h01));
    directed_q.insert(directed_q.size(), make_req(0, 0, 1, 31, 8'h80));
    directed_q.insert(directed_q.size(), make_req(0, 0, 31, 1, 8'h7F));
    directed_q.insert(directed_q.size(), make_req(-1, 0, 0, 1, 8'h23));
    directed_q.insert(directed_q.size(), make_req(0, -1, 1, 0, 8'h24));
    directed_q.insert(directed_q.size(), make_req(-1, 0, 7, 3, 8'hC3));
    directed_q.insert(directed_q.size(), make_req(3, -5, 3, 7, 8'h3C));
    directed_q.insert(directed_q.size(), make_req(-16, 15, 16, 16, 8'hAA));
    directed_q.insert(directed_q.size(), make_req(15, -16, 15, 17, 8'h55));
    directed_q.insert(directed_q.size(), make_req(0, -32, 31, 30, 8'h00));
    directed_q.insert(directed_q.size(), make_req(-32, 31, 2, 2, 8'hFF));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 0: sender rarely idles, receiver mostly stalls
    sent = 0;
    foreach (directed_q[i]) begin
      send_ellipse(directed_q[i]);
      sent++;
    end
    while (sent < ItemsPerPhase) begin
      send_ellipse(random_req());
      sent++;
    end

    // Phase 1: swapped idle rates
    sender_idle_pct <= 84;
    receiver_idle_pct <= 13;
    stim_phase = 1;
    repeat (ItemsPerPhase) send_ellipse(random_req());

    // Phase 2: no idling, plus the long hold-off
    sender_idle_pct <= 0;
    receiver_idle_pct <= 0;
    stim_phase = 2;
    repeat (ItemsPerPhase) send_ellipse(random_req());
    in_valid_i <= 1'b0;

    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (scoreboard.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
